[hw/rtl/sha256_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared widths, round constants, initial hash values, the SHA-256 bit
// functions and the command and status types between controller and datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int WordW     = 32;
	localparam int ByteW     = 8;
	localparam int NumHash   = 8;
	localparam int NumWin    = 16;
	localparam int NumRounds = 64;
	localparam int CountW    = 6;
	localparam int BitCountW = 64;
	localparam int RoundW    = 6;
	localparam int IdxW      = 3;

	localparam logic [ByteW-1:0]  PadMarker = 8'h80;
	localparam logic [CountW-1:0] LastByte  = 6'd63;
	localparam logic [RoundW-1:0] LastRound = 6'd63;
	localparam logic [IdxW-1:0]   LastIdx   = 3'd7;

	localparam logic [WordW-1:0] RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] InitHash [NumHash] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Source of the byte shifted into the block window.
	typedef enum logic [1:0] {
		SEL_MSG  = 2'd0,
		SEL_MARK = 2'd1,
		SEL_ZERO = 2'd2,
		SEL_LEN  = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic              shift;
		byte_sel_t         byte_sel;
		logic              load_vars;
		logic              round_en;
		logic [RoundW-1:0] round_idx;
		logic              add_hash;
		logic              pop_word;
		logic [IdxW-1:0]   word_idx;
	} cmd_t;

	typedef struct packed {
		logic [CountW-1:0] byte_count;
	} sts_t;

	function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [WordW-1:0] choose(
		input logic [WordW-1:0] e,
		input logic [WordW-1:0] f,
		input logic [WordW-1:0] g
	);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [WordW-1:0] majority(
		input logic [WordW-1:0] a,
		input logic [WordW-1:0] b,
		input logic [WordW-1:0] c
	);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

[hw/rtl/sha256_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message channel
// Valid/ready channel that carries one message byte request.
// ----------------------------------------------------------------------------
interface sha256_in_if;

	logic                           valid;
	logic                           ready;
	logic [sha256_pkg::ByteW-1:0]   message_byte;
	logic                           byte_valid;
	logic                           end_of_message;

	modport source (
		output valid, message_byte, byte_valid, end_of_message,
		input  ready
	);

	modport sink (
		input  valid, message_byte, byte_valid, end_of_message,
		output ready
	);

endinterface

[hw/rtl/sha256_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest channel
// Valid/ready channel that carries one digest word request.
// ----------------------------------------------------------------------------
interface sha256_out_if;

	logic                           valid;
	logic                           ready;
	logic [sha256_pkg::WordW-1:0]   digest_word;
	logic [sha256_pkg::IdxW-1:0]    word_index;
	logic                           last_word;

	modport source (
		output valid, digest_word, word_index, last_word,
		input  ready
	);

	modport sink (
		input  valid, digest_word, word_index, last_word,
		output ready
	);

endinterface

[hw/rtl/sha256_message_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with padding and a digest word stream at the end.
// ----------------------------------------------------------------------------
// Each accepted message request carries at most one byte and may end the
// message. The 64th byte of a block starts the shared round unit, which
// runs the 64 rounds one per cycle with the schedule kept in a 16-word
// sliding window, then adds into the hash. At the end of a message the
// padding bytes (marker, zeros and the 64-bit length) are shifted in one
// per cycle through the same window, with 64 more bytes in one more block
// when fewer than nine bytes are free. The eight digest words then leave,
// word 0 first, one per cycle while the sink is ready. No new request is
// taken while a block is compressed or a digest is delivered; afterwards
// the hash is back at its initial values for the next message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	sha256_in_if.sink   message,
	sha256_out_if.source digest
);

	sha256_pkg::cmd_t cmd;
	sha256_pkg::sts_t sts;

	// Sequencer.
	sha256_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (message.valid),
		.byte_valid     (message.byte_valid),
		.end_of_message (message.end_of_message),
		.in_ready       (message.ready),
		.out_valid      (digest.valid),
		.out_ready      (digest.ready),
		.word_index     (digest.word_index),
		.last_word      (digest.last_word),
		.sts            (sts),
		.cmd            (cmd)
	);

	// Block window, round unit and hash state.
	sha256_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_byte (message.message_byte),
		.sts          (sts),
		.digest_word  (digest.digest_word)
	);

endmodule

[hw/rtl/sha256_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block window that doubles as the message schedule, one shared round unit,
// the hash words, the byte counter and the message bit counter.
// ----------------------------------------------------------------------------
module sha256_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sha256_pkg::cmd_t                 cmd,
	input  logic [sha256_pkg::ByteW-1:0]     message_byte,
	output sha256_pkg::sts_t                 sts,
	output logic [sha256_pkg::WordW-1:0]     digest_word
);

	logic [sha256_pkg::WordW-1:0]     win_q  [sha256_pkg::NumWin];
	logic [sha256_pkg::WordW-1:0]     var_q  [sha256_pkg::NumHash];
	logic [sha256_pkg::WordW-1:0]     hash_q [sha256_pkg::NumHash];
	logic [sha256_pkg::CountW-1:0]    count_q;
	logic [sha256_pkg::BitCountW-1:0] bitcnt_q;

	logic [sha256_pkg::ByteW-1:0] new_byte;
	logic [sha256_pkg::WordW-1:0] sched_word;
	logic [sha256_pkg::WordW-1:0] t1;
	logic [sha256_pkg::WordW-1:0] t2;

	// Pick the byte that enters the window.
	always_comb begin
		case (cmd.byte_sel)
			sha256_pkg::SEL_MSG:  new_byte = message_byte;
			sha256_pkg::SEL_MARK: new_byte = sha256_pkg::PadMarker;
			sha256_pkg::SEL_ZERO: new_byte = '0;
			sha256_pkg::SEL_LEN:  new_byte = bitcnt_q[63:56];
			default:              new_byte = '0;
		endcase
	end

	// Next schedule word and the two round sums.
	always_comb begin
		sched_word = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
			+ sha256_pkg::small_sigma0(win_q[1]) + win_q[0];
		t1 = var_q[7] + sha256_pkg::big_sigma1(var_q[4])
			+ sha256_pkg::choose(var_q[4], var_q[5], var_q[6])
			+ sha256_pkg::RoundK[cmd.round_idx] + win_q[0];
		t2 = sha256_pkg::big_sigma0(var_q[0])
			+ sha256_pkg::majority(var_q[0], var_q[1], var_q[2]);
	end

	// The window shifts bytes in while a block is gathered and shifts words
	// through the schedule recurrence during the rounds.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int j = 0; j < sha256_pkg::NumWin - 1; j++) begin
				win_q[j] <= {win_q[j][23:0], win_q[j+1][31:24]};
			end
			win_q[sha256_pkg::NumWin-1] <= {win_q[sha256_pkg::NumWin-1][23:0], new_byte};
		end else if (cmd.round_en) begin
			for (int j = 0; j < sha256_pkg::NumWin - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[sha256_pkg::NumWin-1] <= sched_word;
		end
	end

	// Working variables a to h.
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int j = 0; j < sha256_pkg::NumHash; j++) begin
				var_q[j] <= hash_q[j];
			end
		end else if (cmd.round_en) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// Hash words: accumulate after a block, rotate out on each digest word
	// and refill with the initial values behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < sha256_pkg::NumHash; j++) begin
				hash_q[j] <= sha256_pkg::InitHash[j];
			end
		end else if (cmd.add_hash) begin
			for (int j = 0; j < sha256_pkg::NumHash; j++) begin
				hash_q[j] <= hash_q[j] + var_q[j];
			end
		end else if (cmd.pop_word) begin
			for (int j = 0; j < sha256_pkg::NumHash - 1; j++) begin
				hash_q[j] <= hash_q[j+1];
			end
			hash_q[sha256_pkg::NumHash-1] <= sha256_pkg::InitHash[cmd.word_idx];
		end
	end

	// Byte position in the block and message length in bits. The length
	// shifts out a byte at a time and is zero once fully sent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			bitcnt_q <= '0;
		end else if (cmd.shift) begin
			count_q <= count_q + 6'd1;
			if (cmd.byte_sel == sha256_pkg::SEL_MSG) begin
				bitcnt_q <= bitcnt_q + 64'd8;
			end else if (cmd.byte_sel == sha256_pkg::SEL_LEN) begin
				bitcnt_q <= {bitcnt_q[55:0], 8'h00};
			end
		end
	end

	assign sts.byte_count = count_q;
	assign digest_word    = hash_q[0];

endmodule

[hw/rtl/sha256_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// State machine that sequences byte intake, padding, the 64 rounds, the
// hash update and the delivery of the eight digest words.
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            byte_valid,
	input  logic                            end_of_message,
	output logic                            in_ready,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sha256_pkg::IdxW-1:0]     word_index,
	output logic                            last_word,
	input  sha256_pkg::sts_t                sts,
	output sha256_pkg::cmd_t                cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ROUND = 5'b00010,
		S_FINAL = 5'b00100,
		S_PAD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [sha256_pkg::RoundW-1:0]   round_q;
	logic [sha256_pkg::IdxW-1:0]     idx_q;
	logic                            marker_q;
	logic                            len_ok_q;
	logic                            final_q;
	logic                            pad_pend_q;

	logic                    in_fire;
	logic                    block_full;
	logic                    tail_zone;
	sha256_pkg::byte_sel_t   pad_sel;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign in_fire    = in_valid && in_ready;
	assign block_full = (sts.byte_count == sha256_pkg::LastByte);
	assign tail_zone  = (sts.byte_count[5:3] == 3'b111);
	assign word_index = idx_q;
	assign last_word  = (idx_q == sha256_pkg::LastIdx);

	// Padding byte: the marker first, then zeros, with the length in the last
	// eight bytes of the block that has room for it.
	always_comb begin
		if (!marker_q) begin
			pad_sel = sha256_pkg::SEL_MARK;
		end else if (len_ok_q && tail_zone) begin
			pad_sel = sha256_pkg::SEL_LEN;
		end else begin
			pad_sel = sha256_pkg::SEL_ZERO;
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd           = '0;
		cmd.byte_sel  = sha256_pkg::SEL_MSG;
		cmd.round_idx = round_q;
		cmd.word_idx  = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && byte_valid) begin
					cmd.shift     = 1'b1;
					cmd.load_vars = block_full;
				end
			end
			S_PAD: begin
				cmd.shift     = 1'b1;
				cmd.byte_sel  = pad_sel;
				cmd.load_vars = block_full;
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
			end
			S_FINAL: begin
				cmd.add_hash = 1'b1;
			end
			S_OUT: begin
				cmd.pop_word = out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			round_q    <= '0;
			idx_q      <= '0;
			marker_q   <= 1'b0;
			len_ok_q   <= 1'b0;
			final_q    <= 1'b0;
			pad_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						marker_q   <= 1'b0;
						len_ok_q   <= 1'b0;
						final_q    <= 1'b0;
						pad_pend_q <= byte_valid && block_full && end_of_message;
						round_q    <= '0;
						if (byte_valid && block_full) begin
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					marker_q <= 1'b1;
					// A marker below the tail leaves room for the length here.
					if (!marker_q && !tail_zone) begin
						len_ok_q <= 1'b1;
					end
					if (block_full) begin
						len_ok_q   <= 1'b1;
						final_q    <= (pad_sel == sha256_pkg::SEL_LEN);
						// Without the length in this block, one more padding
						// block follows it.
						pad_pend_q <= (pad_sel != sha256_pkg::SEL_LEN);
						round_q    <= '0;
						state_q    <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == sha256_pkg::LastRound) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					idx_q <= '0;
					if (final_q) begin
						state_q <= S_OUT;
					end else if (pad_pend_q) begin
						pad_pend_q <= 1'b0;
						state_q    <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha256_pkg::LastIdx) begin
							final_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
